FILE: hw/rtl/qia_pkg.sv
// Shared types and constants of the quadratic integer ALU.
// Depends on nothing; qia_front, qia_div_pipe and the top level import it.
`default_nettype none

package qia_pkg;

  localparam int COEFF_WIDTH_DEF = 32;
  localparam int IO_WIDTH        = 32;
  localparam int NORM_WIDTH      = 64;
  localparam int FIELD_D_WIDTH   = 10;
  localparam logic [FIELD_D_WIDTH-1:0] FIELD_D_RESET = 10'd2;

  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_DIV  = 3'd1,
    OP_LESS = 3'd2,
    OP_LEQ  = 3'd3,
    OP_NORM = 3'd4,
    OP_CONJ = 3'd5,
    OP_ADD  = 3'd6,
    OP_SUB  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_DIV  = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_WRAP     = 2'd3
  } status_e;

  typedef struct packed {
    op_e  op;
    logic one4;
    logic a_neg;
    logic a_zero;
    logic b_neg;
    logic b_zero;
  } qia_ctl_t;

  typedef struct packed {
    logic [IO_WIDTH-1:0]   res_rational;
    logic [IO_WIDTH-1:0]   res_irrational;
    logic [NORM_WIDTH-1:0] norm_value;
    logic                  compare_true;
    status_e               status;
  } qia_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qia_in_if.sv
// Input channel of the quadratic integer ALU: one word holds an opcode and two elements.
// Stands alone; carries valid, ready and the payload.
`default_nettype none

interface qia_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic signed [31:0] x_rational;
  logic signed [31:0] x_irrational;
  logic signed [31:0] y_rational;
  logic signed [31:0] y_irrational;

  modport source (output valid, opcode, x_rational, x_irrational, y_rational, y_irrational,
                  input ready);
  modport sink (input valid, opcode, x_rational, x_irrational, y_rational, y_irrational,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/qia_out_if.sv
// Result channel of the quadratic integer ALU: one word holds one result element.
// Stands alone; carries valid, ready and the payload.
`default_nettype none

interface qia_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_rational;
  logic signed [31:0] res_irrational;
  logic signed [63:0] norm_value;
  logic               compare_true;
  logic        [1:0]  status;

  modport source (output valid, res_rational, res_irrational, norm_value, compare_true,
                  status, input ready);
  modport sink (input valid, res_rational, res_irrational, norm_value, compare_true, status,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/qia_front.sv
// Front pipeline of the quadratic integer ALU: input register, products, scaling, sums.
// Four register stages; depends on qia_pkg.
`default_nettype none

module qia_front import qia_pkg::*; #(
  parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             en_i,
  input  wire                             valid_i,
  input  wire op_e                        op_i,
  input  wire signed [COEFF_WIDTH-1:0]    xa_i,
  input  wire signed [COEFF_WIDTH-1:0]    xb_i,
  input  wire signed [COEFF_WIDTH-1:0]    ya_i,
  input  wire signed [COEFF_WIDTH-1:0]    yb_i,
  input  wire        [FIELD_D_WIDTH-1:0]  field_d_i,
  output logic                            valid_o,
  output qia_ctl_t                        ctl_o,
  output logic signed [2*COEFF_WIDTH+13:0] ca_o,
  output logic signed [2*COEFF_WIDTH+13:0] cb_o,
  output logic signed [2*COEFF_WIDTH+13:0] n_o,
  output logic signed [COEFF_WIDTH-1:0]   xa_o,
  output logic signed [COEFF_WIDTH-1:0]   xb_o
);

  localparam int W  = COEFF_WIDTH;
  localparam int WW = 2 * COEFF_WIDTH + 14;

  // Stage A: captured word.
  logic                      a_valid_q;
  op_e                       a_op_q;
  logic signed [W-1:0]       a_xa_q, a_xb_q, a_ya_q, a_yb_q;
  logic [FIELD_D_WIDTH-1:0]  a_d_q;

  // Stage B: first products.
  logic                      b_valid_q;
  qia_ctl_t                  b_ctl_q, b_ctl_d;
  logic signed [2*W:0]       b_p1_q, b_p1_d;
  logic signed [2*W-1:0]     b_p2_q, b_p2_d, b_p3_q, b_p3_d, b_p4_q, b_p4_d;
  logic signed [2*W+6:0]     b_u_q, b_u_d;
  logic signed [2*W+1:0]     b_v_q, b_v_d;
  logic [FIELD_D_WIDTH-1:0]  b_k_q, b_k_d, b_kn_q, b_kn_d;
  logic signed [W:0]         b_la_q, b_la_d, b_lb_q, b_lb_d;
  logic signed [W-1:0]       b_xa_q, b_xb_q;

  // Stage C: scaled products.
  logic                      c_valid_q;
  qia_ctl_t                  c_ctl_q;
  logic signed [2*W:0]       c_p1_q;
  logic signed [2*W-1:0]     c_p2_q, c_p3_q, c_p4_q;
  logic signed [2*W+10:0]    c_p2k_q, c_p2k_d;
  logic signed [2*W+6:0]     c_u_q;
  logic signed [2*W+12:0]    c_vk_q, c_vk_d;
  logic signed [W:0]         c_la_q, c_lb_q;
  logic signed [W-1:0]       c_xa_q, c_xb_q;

  // Stage D: sums.
  logic signed [WW-1:0]      d_ca_d, d_cb_d, d_n_d;

  logic                      one4;
  logic                      is_cmp;
  logic                      one4n;
  logic [FIELD_D_WIDTH-1:0]  q4;
  logic signed [W:0]         yb_sel, t_op;
  logic signed [W+2:0]       dxa, dxb, cmp_a;
  logic signed [W+2:0]       na;
  logic signed [W:0]         nb;
  logic signed [W+3:0]       nb_sel, nsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      valid_o   <= c_valid_q;
    end
  end

  always_comb begin
    one4   = (a_d_q[1:0] == 2'b01);
    is_cmp = (a_op_q == OP_LESS) || (a_op_q == OP_LEQ);
    one4n  = one4 && !is_cmp;
    q4     = one4 ? {2'b00, a_d_q[FIELD_D_WIDTH-1:2]} : '0;
    b_k_d  = one4 ? q4 : a_d_q;
    b_kn_d = one4n ? q4 : a_d_q;

    yb_sel = '0;
    if ((a_op_q == OP_DIV) && one4) begin
      yb_sel = (W+1)'(a_yb_q);
    end
    t_op   = (W+1)'(a_ya_q) + yb_sel;
    b_p1_d = a_xa_q * t_op;
    b_p2_d = a_xb_q * a_yb_q;
    b_p3_d = a_xa_q * a_yb_q;
    b_p4_d = a_xb_q * a_ya_q;

    dxa = (W+3)'(a_xa_q) - (W+3)'(a_ya_q);
    dxb = (W+3)'(a_xb_q) - (W+3)'(a_yb_q);
    if (one4) begin
      cmp_a = (dxa <<< 1) + dxb;
    end else begin
      cmp_a = dxa;
    end

    if (a_op_q == OP_NORM) begin
      na = (W+3)'(a_xa_q);
      nb = (W+1)'(a_xb_q);
    end else if (is_cmp) begin
      na = cmp_a;
      nb = dxb[W:0];
    end else begin
      na = (W+3)'(a_ya_q);
      nb = (W+1)'(a_yb_q);
    end
    nb_sel = '0;
    if (one4n) begin
      nb_sel = (W+4)'(nb);
    end
    nsum  = (W+4)'(na) + nb_sel;
    b_u_d = na * nsum;
    b_v_d = nb * nb;

    b_la_d = '0;
    b_lb_d = '0;
    unique case (a_op_q)
      OP_ADD: begin
        b_la_d = (W+1)'(a_xa_q) + (W+1)'(a_ya_q);
        b_lb_d = (W+1)'(a_xb_q) + (W+1)'(a_yb_q);
      end
      OP_SUB: begin
        b_la_d = (W+1)'(a_xa_q) - (W+1)'(a_ya_q);
        b_lb_d = (W+1)'(a_xb_q) - (W+1)'(a_yb_q);
      end
      OP_CONJ: begin
        b_la_d = one4 ? ((W+1)'(a_xa_q) + (W+1)'(a_xb_q)) : (W+1)'(a_xa_q);
        b_lb_d = -((W+1)'(a_xb_q));
      end
      default: begin
        b_la_d = '0;
        b_lb_d = '0;
      end
    endcase

    b_ctl_d.op     = a_op_q;
    b_ctl_d.one4   = one4;
    b_ctl_d.a_neg  = cmp_a[W+2];
    b_ctl_d.a_zero = (cmp_a == '0);
    b_ctl_d.b_neg  = dxb[W+2];
    b_ctl_d.b_zero = (dxb == '0);
  end

  always_comb begin
    c_p2k_d = b_p2_q * $signed({1'b0, b_k_q});
    c_vk_d  = b_v_q * $signed({1'b0, b_kn_q});
  end

  always_comb begin
    d_n_d = WW'(c_u_q) - WW'(c_vk_q);
    unique case (c_ctl_q.op)
      OP_MUL: begin
        d_ca_d = WW'(c_p1_q) + WW'(c_p2k_q);
        d_cb_d = WW'(c_p3_q) + WW'(c_p4_q);
        if (c_ctl_q.one4) begin
          d_cb_d = d_cb_d + WW'(c_p2_q);
        end
      end
      OP_DIV: begin
        d_ca_d = WW'(c_p1_q) - WW'(c_p2k_q);
        d_cb_d = WW'(c_p4_q) - WW'(c_p3_q);
      end
      OP_ADD, OP_SUB, OP_CONJ: begin
        d_ca_d = WW'(c_la_q);
        d_cb_d = WW'(c_lb_q);
      end
      default: begin
        d_ca_d = '0;
        d_cb_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_op_q  <= op_i;
      a_xa_q  <= xa_i;
      a_xb_q  <= xb_i;
      a_ya_q  <= ya_i;
      a_yb_q  <= yb_i;
      a_d_q   <= field_d_i;

      b_ctl_q <= b_ctl_d;
      b_p1_q  <= b_p1_d;
      b_p2_q  <= b_p2_d;
      b_p3_q  <= b_p3_d;
      b_p4_q  <= b_p4_d;
      b_u_q   <= b_u_d;
      b_v_q   <= b_v_d;
      b_k_q   <= b_k_d;
      b_kn_q  <= b_kn_d;
      b_la_q  <= b_la_d;
      b_lb_q  <= b_lb_d;
      b_xa_q  <= a_xa_q;
      b_xb_q  <= a_xb_q;

      c_ctl_q <= b_ctl_q;
      c_p1_q  <= b_p1_q;
      c_p2_q  <= b_p2_q;
      c_p3_q  <= b_p3_q;
      c_p4_q  <= b_p4_q;
      c_p2k_q <= c_p2k_d;
      c_u_q   <= b_u_q;
      c_vk_q  <= c_vk_d;
      c_la_q  <= b_la_q;
      c_lb_q  <= b_lb_q;
      c_xa_q  <= b_xa_q;
      c_xb_q  <= b_xb_q;

      ctl_o   <= c_ctl_q;
      ca_o    <= d_ca_d;
      cb_o    <= d_cb_d;
      n_o     <= d_n_d;
      xa_o    <= c_xa_q;
      xb_o    <= c_xb_q;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/qia_div_pipe.sv
// Pipelined restoring divider of the quadratic integer ALU: two quotients, one divisor.
// One quotient bit per stage, sideband travels alongside; depends on qia_pkg.
`default_nettype none

module qia_div_pipe import qia_pkg::*; #(
  parameter int WIDTH  = 2 * COEFF_WIDTH_DEF + 14,
  parameter int SIDE_W = 1
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     valid_i,
  input  wire        [SIDE_W-1:0] side_i,
  input  wire        [WIDTH-1:0]  na_i,
  input  wire        [WIDTH-1:0]  nb_i,
  input  wire        [WIDTH-1:0]  den_i,
  input  wire                     neg_a_i,
  input  wire                     neg_b_i,
  output logic                    valid_o,
  output logic       [SIDE_W-1:0] side_o,
  output logic signed [WIDTH:0]   qa_o,
  output logic signed [WIDTH:0]   qb_o,
  output logic                    exact_o
);

  logic [WIDTH:0]       valid_q;
  logic [WIDTH:0]       nega_q, negb_q;
  logic [SIDE_W-1:0]    side_q [WIDTH+1];
  logic [WIDTH-1:0]     ra_q   [WIDTH+1];
  logic [WIDTH-1:0]     na_q   [WIDTH+1];
  logic [WIDTH-1:0]     rb_q   [WIDTH+1];
  logic [WIDTH-1:0]     nb_q   [WIDTH+1];
  logic [WIDTH-1:0]     den_q  [WIDTH+1];
  logic [WIDTH:0]       qa_mag, qb_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[WIDTH-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      ra_q[0]   <= '0;
      na_q[0]   <= na_i;
      rb_q[0]   <= '0;
      nb_q[0]   <= nb_i;
      den_q[0]  <= den_i;
      nega_q[0] <= neg_a_i;
      negb_q[0] <= neg_b_i;
    end
  end

  for (genvar s = 0; s < WIDTH; s++) begin : g_step
    logic [WIDTH:0] rsa, dfa, rsb, dfb;

    assign rsa = {ra_q[s], na_q[s][WIDTH-1]};
    assign dfa = rsa - {1'b0, den_q[s]};
    assign rsb = {rb_q[s], nb_q[s][WIDTH-1]};
    assign dfb = rsb - {1'b0, den_q[s]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s+1] <= side_q[s];
        den_q[s+1]  <= den_q[s];
        nega_q[s+1] <= nega_q[s];
        negb_q[s+1] <= negb_q[s];
        ra_q[s+1]   <= dfa[WIDTH] ? rsa[WIDTH-1:0] : dfa[WIDTH-1:0];
        na_q[s+1]   <= {na_q[s][WIDTH-2:0], ~dfa[WIDTH]};
        rb_q[s+1]   <= dfb[WIDTH] ? rsb[WIDTH-1:0] : dfb[WIDTH-1:0];
        nb_q[s+1]   <= {nb_q[s][WIDTH-2:0], ~dfb[WIDTH]};
      end
    end
  end

  assign qa_mag  = {1'b0, na_q[WIDTH]};
  assign qb_mag  = {1'b0, nb_q[WIDTH]};
  assign qa_o    = nega_q[WIDTH] ? (~qa_mag + 1'b1) : qa_mag;
  assign qb_o    = negb_q[WIDTH] ? (~qb_mag + 1'b1) : qb_mag;
  assign exact_o = (ra_q[WIDTH] == '0) && (rb_q[WIDTH] == '0);
  assign valid_o = valid_q[WIDTH];
  assign side_o  = side_q[WIDTH];

endmodule

`default_nettype wire

FILE: hw/rtl/quadratic_integer_alu_core.sv
// Quadratic integer ALU, top level: field register, front pipeline, divider, output skid.
// Every opcode passes through the divider; one word per cycle while the skid stage is empty.
// The divider resolves one quotient bit per stage over 2*COEFF_WIDTH+14 bits.
// The output register and a one-word skid stage keep input ready registered.
// Reset is asynchronous, active low; it empties the pipeline and sets field_d to 2.
`default_nettype none

module quadratic_integer_alu_core import qia_pkg::*; #(
  parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [FIELD_D_WIDTH-1:0]  cfg_wdata_i,
  qia_in_if.sink                   in_i,
  qia_out_if.source                out_o
);

  localparam int W  = COEFF_WIDTH;
  localparam int WW = 2 * COEFF_WIDTH + 14;
  localparam int NX = WW + NORM_WIDTH;

  typedef struct packed {
    logic                  live;
    status_e               status;
    logic                  cmp;
    logic [NORM_WIDTH-1:0] nv;
    logic [W-1:0]          ra;
    logic [W-1:0]          rb;
  } side_t;

  logic [FIELD_D_WIDTH-1:0] field_d_q;
  logic                     en;

  logic                     f_valid;
  qia_ctl_t                 f_ctl;
  logic signed [WW-1:0]     f_ca, f_cb, f_n;
  logic signed [W-1:0]      f_xa, f_xb;

  side_t                    side_d, side_o;
  logic [WW-1:0]            ca_mag, cb_mag, n_mag;
  logic signed [NX-1:0]     n_ext;
  logic                     ca_fit, cb_fit, n_fit, n_zero, lt, eq;

  logic                     div_valid;
  logic [$bits(side_t)-1:0] div_side;
  logic signed [WW:0]       qa, qb;
  logic                     exact;
  logic                     qa_fit, qb_fit;
  logic signed [W-1:0]      ra_w, rb_w;
  qia_res_t                 res_d;

  logic                     out_v_q, skid_v_q;
  qia_res_t                 out_q, skid_q;
  logic                     in_word, take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_d_q <= FIELD_D_RESET;
    end else if (cfg_we_i) begin
      field_d_q <= cfg_wdata_i;
    end
  end

  assign en = !skid_v_q;
  assign in_i.ready = en;

  qia_front #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_i.valid),
    .op_i      (op_e'(in_i.opcode)),
    .xa_i      (in_i.x_rational[W-1:0]),
    .xb_i      (in_i.x_irrational[W-1:0]),
    .ya_i      (in_i.y_rational[W-1:0]),
    .yb_i      (in_i.y_irrational[W-1:0]),
    .field_d_i (field_d_q),
    .valid_o   (f_valid),
    .ctl_o     (f_ctl),
    .ca_o      (f_ca),
    .cb_o      (f_cb),
    .n_o       (f_n),
    .xa_o      (f_xa),
    .xb_o      (f_xb)
  );

  always_comb begin
    ca_fit = (&f_ca[WW-1:W-1]) | ~(|f_ca[WW-1:W-1]);
    cb_fit = (&f_cb[WW-1:W-1]) | ~(|f_cb[WW-1:W-1]);
    n_ext  = NX'(f_n);
    n_fit  = (&n_ext[NX-1:NORM_WIDTH-1]) | ~(|n_ext[NX-1:NORM_WIDTH-1]);
    n_zero = (f_n == '0);
    ca_mag = f_ca[WW-1] ? -f_ca : f_ca;
    cb_mag = f_cb[WW-1] ? -f_cb : f_cb;
    n_mag  = f_n[WW-1] ? -f_n : f_n;

    if (f_ctl.a_neg) begin
      if (f_ctl.b_neg || f_ctl.b_zero) begin
        lt = 1'b1;
        eq = 1'b0;
      end else begin
        lt = !f_n[WW-1] && !n_zero;
        eq = n_zero;
      end
    end else if (!f_ctl.b_neg) begin
      lt = 1'b0;
      eq = f_ctl.a_zero && f_ctl.b_zero;
    end else begin
      lt = f_n[WW-1];
      eq = n_zero;
    end

    side_d        = '0;
    side_d.status = ST_OK;
    unique case (f_ctl.op)
      OP_MUL, OP_ADD, OP_SUB, OP_CONJ: begin
        side_d.ra     = f_ca[W-1:0];
        side_d.rb     = f_cb[W-1:0];
        side_d.status = (ca_fit && cb_fit) ? ST_OK : ST_WRAP;
      end
      OP_DIV: begin
        side_d.ra     = f_xa;
        side_d.rb     = f_xb;
        side_d.live   = !n_zero;
        side_d.status = n_zero ? ST_DIV_ZERO : ST_OK;
      end
      OP_LESS: begin
        side_d.cmp = lt;
      end
      OP_LEQ: begin
        side_d.cmp = lt || eq;
      end
      OP_NORM: begin
        side_d.nv     = n_ext[NORM_WIDTH-1:0];
        side_d.status = n_fit ? ST_OK : ST_WRAP;
      end
      default: begin
        side_d.status = ST_OK;
      end
    endcase
  end

  qia_div_pipe #(
    .WIDTH  (WW),
    .SIDE_W ($bits(side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .side_i  (side_d),
    .na_i    (ca_mag),
    .nb_i    (cb_mag),
    .den_i   (n_mag),
    .neg_a_i (f_ca[WW-1] ^ f_n[WW-1]),
    .neg_b_i (f_cb[WW-1] ^ f_n[WW-1]),
    .valid_o (div_valid),
    .side_o  (div_side),
    .qa_o    (qa),
    .qb_o    (qb),
    .exact_o (exact)
  );

  always_comb begin
    side_o = side_t'(div_side);
    qa_fit = (&qa[WW:W-1]) | ~(|qa[WW:W-1]);
    qb_fit = (&qb[WW:W-1]) | ~(|qb[WW:W-1]);
    ra_w   = side_o.ra;
    rb_w   = side_o.rb;
    res_d.status = side_o.status;
    if (side_o.live) begin
      if (exact) begin
        ra_w         = qa[W-1:0];
        rb_w         = qb[W-1:0];
        res_d.status = (qa_fit && qb_fit) ? ST_OK : ST_WRAP;
      end else begin
        res_d.status = ST_NOT_DIV;
      end
    end
    res_d.res_rational   = IO_WIDTH'(ra_w);
    res_d.res_irrational = IO_WIDTH'(rb_w);
    res_d.norm_value     = side_o.nv;
    res_d.compare_true   = side_o.cmp;
  end

  assign in_word = div_valid && en;
  assign take    = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_word;
      end
    end else if (in_word) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (in_word) begin
        out_q <= res_d;
      end
    end else if (in_word) begin
      skid_q <= res_d;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.res_rational   = out_q.res_rational;
  assign out_o.res_irrational = out_q.res_irrational;
  assign out_o.norm_value     = out_q.norm_value;
  assign out_o.compare_true   = out_q.compare_true;
  assign out_o.status         = out_q.status;

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid stage filled while the output register was free");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage holds a word while the output register is empty");

  a_cmp_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_o.compare_true) |-> (out_o.status == ST_OK))
    else $error("comparison result carries a nonzero status");

  a_norm_coeff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_o.norm_value != '0)) |->
      ((out_o.res_rational == '0) && (out_o.res_irrational == '0)))
    else $error("norm result carries nonzero coefficients");

endmodule

`default_nettype wire
